// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps

package stt_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int PERIOD_W = 16;
   localparam int MODE_W   = 2;
   localparam int TASK_W   = 8;
   localparam int CODE_W   = 2;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_ADD  = 1'b1;

   localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd1;

   localparam logic [CODE_W-1:0] CODE_FIRED = 2'd0;
   localparam logic [CODE_W-1:0] CODE_ADDED = 2'd1;
   localparam logic [CODE_W-1:0] CODE_FULL  = 2'd2;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                oneshot;
      logic [TASK_W-1:0]   task_id;
      logic [PERIOD_W-1:0] ticks;
   } entry_type;

   typedef struct packed {
      logic                fire;
      logic                drop;
      logic [PERIOD_W-1:0] ticks;
   } eval_type;

endpackage

// ===== src/stt_req_if.sv =====
`timescale 1ns / 1ps

interface stt_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [stt_pkg::PERIOD_W-1:0]  period;
   logic [stt_pkg::MODE_W-1:0]    mode;
   logic [stt_pkg::TASK_W-1:0]    task_id;

   modport source (output valid, output req_type, output period, output mode,
                   output task_id, input ready);
   modport sink   (input valid, input req_type, input period, input mode,
                   input task_id, output ready);
endinterface

// ===== src/stt_rsp_if.sv =====
`timescale 1ns / 1ps

interface stt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [stt_pkg::CODE_W-1:0]    result_code;
   logic [stt_pkg::TASK_W-1:0]    fired_id;
   logic                          last;

   modport source (output valid, output result_code, output fired_id, output last,
                   input ready);
   modport sink   (input valid, input result_code, input fired_id, input last,
                   output ready);
endinterface

// ===== src/stt_slot_eval.sv =====
`timescale 1ns / 1ps

// One tick applied to one entry: advance, compare against period, decide removal.
module stt_slot_eval (
   input  stt_pkg::entry_type entry,
   output stt_pkg::eval_type  result
);

   logic [stt_pkg::PERIOD_W-1:0] ticks_inc;

   assign ticks_inc = entry.ticks + stt_pkg::PERIOD_W'(1);

   always_comb begin
      result.fire  = (ticks_inc >= entry.period);
      result.drop  = result.fire && entry.oneshot;
      result.ticks = result.fire ? '0 : ticks_inc;
   end

endmodule

// ===== src/software_timer_table.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    req_type, period, mode, task_id
// rsp_ch    out  valid/ready    result_code, fired_id, last
//
// Add: accept, then the result leaves the pending register through flush.
// Tick: walks the active slots in order, one result per fire (none on an empty table);
//   one slot per cycle through the RAM read/evaluate/write-back loop unless stalled.
// The walk stops only while a slot fires with one already queued and rsp_ch stalled;
//   the final result of an add or a firing tick waits in flush for the output register.
// Sync reset empties the table, RAM left as is; one transaction in flight, ready when idle.

module software_timer_table #(
   parameter int SLOTS = stt_pkg::SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   stt_req_if.sink    req_ch,
   stt_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   // control state
   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;       // slot being evaluated
   logic [CNT_W-1:0]  wptr_ff, wptr_in;     // compaction write pointer
   logic              pend_vld_ff, pend_vld_in;
   logic [stt_pkg::CODE_W-1:0] pend_code_ff, pend_code_in;
   logic [stt_pkg::TASK_W-1:0] pend_id_ff, pend_id_in;

   // output register
   logic              rsp_vld_ff, rsp_vld_in;
   logic [stt_pkg::CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [stt_pkg::TASK_W-1:0] rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   // entry RAM
   stt_pkg::entry_type mem [SLOTS];
   stt_pkg::entry_type rd_data_ff;
   stt_pkg::entry_type wr_data;
   logic              rd_en, wr_en;
   logic [IDX_W-1:0]  rd_addr, wr_addr;

   stt_pkg::eval_type ev;

   logic req_acc, out_busy, emit, emit_last, last_slot, stall;
   logic [stt_pkg::CODE_W-1:0] emit_code;
   logic [stt_pkg::TASK_W-1:0] emit_id;

   stt_slot_eval u_eval (
      .entry  (rd_data_ff),
      .result (ev)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_busy     = rsp_vld_ff && !rsp_ch.ready;
   assign last_slot    = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   // a second fire cannot be queued while the earlier one has nowhere to go
   assign stall        = ev.fire && pend_vld_ff && out_busy;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wptr_in      = wptr_ff;
      pend_vld_in  = pend_vld_ff;
      pend_code_in = pend_code_ff;
      pend_id_in   = pend_id_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = wptr_ff[IDX_W-1:0];
      wr_data      = rd_data_ff;
      emit         = 1'b0;
      emit_code    = pend_code_ff;
      emit_id      = pend_id_ff;
      emit_last    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.req_type == stt_pkg::REQ_ADD) begin
                  pend_vld_in = 1'b1;
                  pend_id_in  = req_ch.task_id;
                  if (count_ff == CNT_W'(SLOTS)) begin
                     pend_code_in = stt_pkg::CODE_FULL;
                  end else begin
                     pend_code_in    = stt_pkg::CODE_ADDED;
                     wr_en           = 1'b1;
                     wr_addr         = count_ff[IDX_W-1:0];
                     wr_data.period  = req_ch.period;
                     wr_data.oneshot = (req_ch.mode == stt_pkg::MODE_ONESHOT);
                     wr_data.task_id = req_ch.task_id;
                     wr_data.ticks   = '0;
                     count_in        = count_ff + CNT_W'(1);
                  end
                  state_in = ST_FLUSH;
               end else if (count_ff != '0) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  wptr_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               wr_en         = !ev.drop;
               wr_data.ticks = ev.ticks;
               wptr_in       = wptr_ff + CNT_W'(!ev.drop);
               if (ev.fire) begin
                  // older fire goes out now; this one waits to learn if it is last
                  emit         = pend_vld_ff;
                  pend_vld_in  = 1'b1;
                  pend_code_in = stt_pkg::CODE_FIRED;
                  pend_id_in   = rd_data_ff.task_id;
               end
               if (last_slot) begin
                  count_in = wptr_ff + CNT_W'(!ev.drop);
                  state_in = (ev.fire || pend_vld_ff) ? ST_FLUSH : ST_IDLE;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!out_busy) begin
               emit        = 1'b1;
               emit_last   = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_ch.ready;
      rsp_code_in = rsp_code_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_vld_in  = 1'b1;
         rsp_code_in = emit_code;
         rsp_id_in   = emit_id;
         rsp_last_in = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         idx_ff      <= '0;
         wptr_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         idx_ff      <= idx_in;
         wptr_ff     <= wptr_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_code_ff <= pend_code_in;
      pend_id_ff   <= pend_id_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // entry RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.result_code = rsp_code_ff;
   assign rsp_ch.fired_id    = rsp_id_ff;
   assign rsp_ch.last        = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("entry count above table size");

   a_wptr_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (wptr_ff <= CNT_W'(idx_ff)))
      else $error("compaction pointer ahead of read slot");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("result still queued while idle");

   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_ch.req_type == stt_pkg::REQ_ADD && count_ff == CNT_W'(SLOTS))
      |=> $stable(count_ff))
      else $error("add to full table changed the count");

   a_flush_has_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> pend_vld_ff)
      else $error("flush with nothing queued");

endmodule
